// ----- hdl/monte_carlo_option_pricer_assert.svh -----
// Assertion macros for the option pricer
`ifndef MONTE_CARLO_OPTION_PRICER_ASSERT_SVH
`define MONTE_CARLO_OPTION_PRICER_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define MCOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define MCOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/mcop_pkg.sv -----
// Shared types and constants of the option pricer
package mcop_pkg;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [3:0]  EXP_TERMS = 4'd12;

  localparam logic [3:0] CFG_START   = 4'd0;
  localparam logic [3:0] CFG_STRIKE  = 4'd1;
  localparam logic [3:0] CFG_DRIFT   = 4'd2;
  localparam logic [3:0] CFG_VOL     = 4'd3;
  localparam logic [3:0] CFG_DISC    = 4'd4;
  localparam logic [3:0] CFG_STEPS   = 4'd5;
  localparam logic [3:0] CFG_PATHS   = 4'd6;
  localparam logic [3:0] CFG_PUT     = 4'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_XMUL, ST_XADD, ST_KDIV, ST_KFIN, ST_TMUL, ST_TDIV, ST_TQ,
    ST_PMUL, ST_PSH, ST_PAY, ST_PACC, ST_AVG, ST_SQ, ST_MEAN, ST_M2,
    ST_MSQ, ST_VDIV, ST_SQRT, ST_OUT
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // ceil(2^33 / i), exact floor division of values below 2^30 after >> 33
  function automatic logic [31:0] recip(input logic [3:0] i);
    logic [31:0] m;
    case (i)
      4'd3:    m = 32'd2863311531;
      4'd4:    m = 32'd2147483648;
      4'd5:    m = 32'd1717986919;
      4'd6:    m = 32'd1431655766;
      4'd7:    m = 32'd1227133514;
      4'd8:    m = 32'd1073741824;
      4'd9:    m = 32'd954437177;
      4'd10:   m = 32'd858993460;
      4'd11:   m = 32'd780903145;
      4'd12:   m = 32'd715827883;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/mcop_if.sv -----
// Valid/ready channel interfaces for sample input and block results
interface mcop_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] z_sample;
  modport source(output valid, output z_sample, input ready);
  modport sink(input valid, input z_sample, output ready);
endinterface

interface mcop_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_number;
  logic [31:0] running_mean;
  logic [31:0] running_error;
  modport source(output valid, output block_number, output running_mean,
                 output running_error, input ready);
  modport sink(input valid, input block_number, input running_mean,
               input running_error, output ready);
endinterface

// ----- hdl/monte_carlo_option_pricer.sv -----
// Monte Carlo European option pricer on a geometric Brownian motion path.
// One standard normal sample per beat moves the path price by one step;
// the block takes no new beat until that step is done. One shared 33x33
// multiplier is reused for the exponent, a range reduction by ln2 and a
// 12-term Taylor series. The last step of a path also computes the
// discounted payoff. The last path of a block also computes the block
// statistics: up to four passes of the shared divider and a square root.
// A finished result waits in an output register while the next beat is
// taken.
module monte_carlo_option_pricer #(
  parameter int unsigned MAX_STEPS = 1024,
  parameter int unsigned MAX_PATHS = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  mcop_in_if.sink           in_ch,
  mcop_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  `include "monte_carlo_option_pricer_assert.svh"

  localparam int SW = ($clog2(MAX_STEPS + 1) > 11) ? $clog2(MAX_STEPS + 1) : 11;
  localparam int PW = ($clog2(MAX_PATHS + 1) > 16) ? $clog2(MAX_PATHS + 1) : 16;

  logic [31:0]        start_r, start_nxt, strike_r, strike_nxt, disc_r, disc_nxt;
  logic signed [31:0] drift_r, drift_nxt, vol_r, vol_nxt;
  logic [10:0]        spp_r, spp_nxt;
  logic [15:0]        ppb_r, ppb_nxt;
  logic               put_r, put_nxt;

  mcop_pkg::st_t      state_r, state_nxt;
  logic signed [15:0] z_r, z_nxt;
  logic signed [65:0] p_r, p_nxt;
  logic               neg_r, neg_nxt;
  logic [34:0]        a_r, a_nxt;
  logic [5:0]         q_r, q_nxt;
  logic [2:0]         kcnt_r, kcnt_nxt;
  logic [29:0]        r_r, r_nxt;
  logic [5:0]         sh_r, sh_nxt;
  logic [30:0]        term_r, term_nxt;
  logic [31:0]        e_r, e_nxt;
  logic [3:0]         i_r, i_nxt;
  logic [31:0]        price_r, price_nxt;
  logic [9:0]         step_r, step_nxt;
  logic [15:0]        path_r, path_nxt;
  logic [47:0]        bsum_r, bsum_nxt;
  logic [15:0]        blocks_r, blocks_nxt;
  logic [47:0]        savg_r, savg_nxt;
  logic [63:0]        ssq_r, ssq_nxt;
  logic [31:0]        mean_r, mean_nxt;
  logic [63:0]        m2_r, m2_nxt;
  logic [63:0]        sv_r, sv_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]         sqcnt_r, sqcnt_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [15:0]        oblk_r, oblk_nxt;
  logic [31:0]        omean_r, omean_nxt, oerr_r, oerr_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               div_start;
  logic [63:0]        div_dvd, div_q;
  logic [15:0]        div_dvs;
  mcop_pkg::div_sts_t div_sts;

  logic [SW-1:0]      steps_eff;
  logic [PW-1:0]      paths_eff;
  logic signed [65:0] xs;
  logic [35:0]        x, dl;
  logic [29:0]        v, tq;
  logic               tupd;
  logic [63:0]        shv, var_v, sqt;
  logic [31:0]        payoff;
  logic [64:0]        ssum;
  logic               out_load;

  mcop_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (SW'(spp_r) == '0) steps_eff = SW'(1);
    else if (SW'(spp_r) > SW'(MAX_STEPS)) steps_eff = SW'(MAX_STEPS);
    else steps_eff = SW'(spp_r);
    if (PW'(ppb_r) == '0) paths_eff = PW'(1);
    else if (PW'(ppb_r) > PW'(MAX_PATHS)) paths_eff = PW'(MAX_PATHS);
    else paths_eff = PW'(ppb_r);
  end

  always_comb begin
    start_nxt = start_r; strike_nxt = strike_r; drift_nxt = drift_r;
    vol_nxt = vol_r; disc_nxt = disc_r; spp_nxt = spp_r; ppb_nxt = ppb_r;
    put_nxt = put_r;
    state_nxt = state_r; z_nxt = z_r; p_nxt = mul_p; neg_nxt = neg_r;
    a_nxt = a_r; q_nxt = q_r; kcnt_nxt = kcnt_r; r_nxt = r_r; sh_nxt = sh_r;
    term_nxt = term_r; e_nxt = e_r; i_nxt = i_r; price_nxt = price_r;
    step_nxt = step_r; path_nxt = path_r; bsum_nxt = bsum_r;
    blocks_nxt = blocks_r; savg_nxt = savg_r; ssq_nxt = ssq_r;
    mean_nxt = mean_r; m2_nxt = m2_r; sv_nxt = sv_r; res_nxt = res_r;
    bit_nxt = bit_r; sqcnt_nxt = sqcnt_r;
    ovalid_nxt = ovalid_r; oblk_nxt = oblk_r; omean_nxt = omean_r;
    oerr_nxt = oerr_r;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_dvd = '0; div_dvs = '0;
    xs = p_r >>> 12;
    x = 36'({{4{drift_r[31]}}, drift_r} + xs[35:0]);
    dl = 36'({6'b0, mcop_pkg::LN2_Q30}) << kcnt_r;
    v = p_r[59:30];
    tq = '0; tupd = 1'b0;
    shv = p_r[63:0] >> sh_r;
    var_v = '0;
    sqt = res_r + bit_r;
    ssum = {1'b0, ssq_r} + {1'b0, p_r[63:0]};
    if (put_r) payoff = (strike_r > price_r) ? strike_r - price_r : '0;
    else payoff = (price_r > strike_r) ? price_r - strike_r : '0;
    out_load = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        mcop_pkg::CFG_START:  start_nxt = cfg_data;
        mcop_pkg::CFG_STRIKE: strike_nxt = cfg_data;
        mcop_pkg::CFG_DRIFT:  drift_nxt = cfg_data;
        mcop_pkg::CFG_VOL:    vol_nxt = cfg_data;
        mcop_pkg::CFG_DISC:   disc_nxt = cfg_data;
        mcop_pkg::CFG_STEPS:  spp_nxt = cfg_data[10:0];
        mcop_pkg::CFG_PATHS:  ppb_nxt = cfg_data[15:0];
        mcop_pkg::CFG_PUT:    put_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;

    case (state_r)
      mcop_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          z_nxt = in_ch.z_sample;
          state_nxt = mcop_pkg::ST_XMUL;
        end
      end
      mcop_pkg::ST_XMUL: begin
        mul_a = {vol_r[31], vol_r};
        mul_b = {{17{z_r[15]}}, z_r};
        state_nxt = mcop_pkg::ST_XADD;
      end
      mcop_pkg::ST_XADD: begin
        // negative exponent: reduce -x-1 and fold back afterwards
        neg_nxt = x[35];
        a_nxt = x[35] ? ~x[34:0] : x[34:0];
        q_nxt = '0;
        kcnt_nxt = 3'd5;
        state_nxt = mcop_pkg::ST_KDIV;
      end
      mcop_pkg::ST_KDIV: begin
        if ({1'b0, a_r} >= dl) begin
          a_nxt = 35'({1'b0, a_r} - dl);
          q_nxt[kcnt_r] = 1'b1;
        end
        kcnt_nxt = 3'(kcnt_r - 3'd1);
        if (kcnt_r == 3'd0) state_nxt = mcop_pkg::ST_KFIN;
      end
      mcop_pkg::ST_KFIN: begin
        r_nxt = neg_r ? 30'(mcop_pkg::LN2_Q30 - 30'd1 - a_r[29:0]) : a_r[29:0];
        sh_nxt = neg_r ? 6'(6'd31 + q_r) : 6'(6'd30 - q_r);
        term_nxt = mcop_pkg::ONE_Q30;
        e_nxt = {1'b0, mcop_pkg::ONE_Q30};
        i_nxt = 4'd1;
        state_nxt = mcop_pkg::ST_TMUL;
      end
      mcop_pkg::ST_TMUL: begin
        mul_a = {2'b0, term_r};
        mul_b = {3'b0, r_r};
        state_nxt = mcop_pkg::ST_TDIV;
      end
      mcop_pkg::ST_TDIV: begin
        if (i_r == 4'd1) begin
          tq = v; tupd = 1'b1;
        end else if (i_r == 4'd2) begin
          tq = v >> 1; tupd = 1'b1;
        end else begin
          mul_a = {3'b0, v};
          mul_b = {1'b0, mcop_pkg::recip(i_r)};
          state_nxt = mcop_pkg::ST_TQ;
        end
      end
      mcop_pkg::ST_TQ: begin
        tq = p_r[62:33];
        tupd = 1'b1;
      end
      mcop_pkg::ST_PMUL: begin
        mul_a = {1'b0, price_r};
        mul_b = {1'b0, e_r};
        state_nxt = mcop_pkg::ST_PSH;
      end
      mcop_pkg::ST_PSH: begin
        price_nxt = (|shv[63:32]) ? '1 : shv[31:0];
        if (SW'(step_r) + SW'(1) < steps_eff) begin
          step_nxt = 10'(step_r + 10'd1);
          state_nxt = mcop_pkg::ST_IDLE;
        end else begin
          state_nxt = mcop_pkg::ST_PAY;
        end
      end
      mcop_pkg::ST_PAY: begin
        mul_a = {1'b0, payoff};
        mul_b = {1'b0, disc_r};
        state_nxt = mcop_pkg::ST_PACC;
      end
      mcop_pkg::ST_PACC: begin
        price_nxt = start_r;
        step_nxt = '0;
        if ({1'b0, PW'(path_r)} + (PW + 1)'(1) < {1'b0, paths_eff}) begin
          bsum_nxt = 48'(bsum_r + {16'b0, p_r[63:32]});
          path_nxt = 16'(path_r + 16'd1);
          state_nxt = mcop_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          div_dvd = {16'b0, 48'(bsum_r + {16'b0, p_r[63:32]})};
          div_dvs = 16'(path_r + 16'd1);
          bsum_nxt = '0;
          path_nxt = '0;
          state_nxt = mcop_pkg::ST_AVG;
        end
      end
      mcop_pkg::ST_AVG: begin
        if (div_sts.done) begin
          // block counter full: statistics restart
          if (blocks_r == 16'hFFFF) begin
            blocks_nxt = 16'd1;
            savg_nxt = {16'b0, div_q[31:0]};
            ssq_nxt = '0;
          end else begin
            blocks_nxt = 16'(blocks_r + 16'd1);
            savg_nxt = 48'(savg_r + {16'b0, div_q[31:0]});
          end
          mul_a = {1'b0, div_q[31:0]};
          mul_b = {1'b0, div_q[31:0]};
          state_nxt = mcop_pkg::ST_SQ;
        end
      end
      mcop_pkg::ST_SQ: begin
        ssq_nxt = ssum[64] ? '1 : ssum[63:0];
        div_start = 1'b1;
        div_dvd = {16'b0, savg_r};
        div_dvs = blocks_r;
        state_nxt = mcop_pkg::ST_MEAN;
      end
      mcop_pkg::ST_MEAN: begin
        if (div_sts.done) begin
          mean_nxt = div_q[31:0];
          if (blocks_r == 16'd1) begin
            res_nxt = '0;
            state_nxt = mcop_pkg::ST_OUT;
          end else begin
            mul_a = {1'b0, div_q[31:0]};
            mul_b = {1'b0, div_q[31:0]};
            state_nxt = mcop_pkg::ST_M2;
          end
        end
      end
      mcop_pkg::ST_M2: begin
        m2_nxt = p_r[63:0];
        div_start = 1'b1;
        div_dvd = ssq_r;
        div_dvs = blocks_r;
        state_nxt = mcop_pkg::ST_MSQ;
      end
      mcop_pkg::ST_MSQ: begin
        if (div_sts.done) begin
          var_v = (div_q > m2_r) ? div_q - m2_r : '0;
          div_start = 1'b1;
          div_dvd = var_v;
          div_dvs = 16'(blocks_r - 16'd1);
          state_nxt = mcop_pkg::ST_VDIV;
        end
      end
      mcop_pkg::ST_VDIV: begin
        if (div_sts.done) begin
          sv_nxt = div_q;
          res_nxt = '0;
          bit_nxt = 64'h4000_0000_0000_0000;
          sqcnt_nxt = '0;
          state_nxt = mcop_pkg::ST_SQRT;
        end
      end
      mcop_pkg::ST_SQRT: begin
        if (sv_r >= sqt) begin
          sv_nxt = sv_r - sqt;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        sqcnt_nxt = 5'(sqcnt_r + 5'd1);
        if (sqcnt_r == 5'd31) state_nxt = mcop_pkg::ST_OUT;
      end
      mcop_pkg::ST_OUT: begin
        if (!ovalid_r || out_ch.ready) begin
          out_load = 1'b1;
          ovalid_nxt = 1'b1;
          oblk_nxt = blocks_r;
          omean_nxt = mean_r;
          oerr_nxt = res_r[31:0];
          state_nxt = mcop_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcop_pkg::ST_IDLE;
    endcase

    if (tupd) begin
      term_nxt = {1'b0, tq};
      e_nxt = 32'(e_r + {2'b0, tq});
      state_nxt = mcop_pkg::ST_TMUL;
      if (i_r == mcop_pkg::EXP_TERMS) state_nxt = mcop_pkg::ST_PMUL;
      else i_nxt = 4'(i_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 32'd6553600;
      strike_r <= 32'd6553600;
      drift_r  <= 32'sd738198;
      vol_r    <= 32'sd26843546;
      disc_r   <= 32'd3886247062;
      spp_r    <= 11'd100;
      ppb_r    <= 16'd1000;
      put_r    <= 1'b0;
      state_r  <= mcop_pkg::ST_IDLE;
      price_r  <= 32'd6553600;
      step_r   <= '0;
      path_r   <= '0;
      bsum_r   <= '0;
      blocks_r <= '0;
      savg_r   <= '0;
      ssq_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      start_r  <= start_nxt;
      strike_r <= strike_nxt;
      drift_r  <= drift_nxt;
      vol_r    <= vol_nxt;
      disc_r   <= disc_nxt;
      spp_r    <= spp_nxt;
      ppb_r    <= ppb_nxt;
      put_r    <= put_nxt;
      state_r  <= state_nxt;
      price_r  <= price_nxt;
      step_r   <= step_nxt;
      path_r   <= path_nxt;
      bsum_r   <= bsum_nxt;
      blocks_r <= blocks_nxt;
      savg_r   <= savg_nxt;
      ssq_r    <= ssq_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r     <= z_nxt;
    p_r     <= p_nxt;
    neg_r   <= neg_nxt;
    a_r     <= a_nxt;
    q_r     <= q_nxt;
    kcnt_r  <= kcnt_nxt;
    r_r     <= r_nxt;
    sh_r    <= sh_nxt;
    term_r  <= term_nxt;
    e_r     <= e_nxt;
    i_r     <= i_nxt;
    mean_r  <= mean_nxt;
    m2_r    <= m2_nxt;
    sv_r    <= sv_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    sqcnt_r <= sqcnt_nxt;
    oblk_r  <= oblk_nxt;
    omean_r <= omean_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign in_ch.ready          = (state_r == mcop_pkg::ST_IDLE);
  assign out_ch.valid         = ovalid_r;
  assign out_ch.block_number  = oblk_r;
  assign out_ch.running_mean  = omean_r;
  assign out_ch.running_error = oerr_r;

  `MCOP_ASSERT_NOW(a_div_start_free, div_start, !div_sts.busy, "divider restarted while busy")
  `MCOP_ASSERT_NEXT(a_accept_starts_step, in_ch.valid && in_ch.ready, state_r == mcop_pkg::ST_XMUL, "accepted beat did not start a step")
  `MCOP_ASSERT_NEXT(a_result_block_nonzero, out_load, out_ch.valid && out_ch.block_number != 16'd0, "result with zero block number")

endmodule

// ----- hdl/mcop_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 16-bit divisor
module mcop_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [15:0]         divisor,
  output mcop_pkg::div_sts_t  sts,
  output logic [63:0]         quotient
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_sh;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, dvd_r[63]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(rem_sh - {1'b0, dvs_r});
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[15:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = 6'(cnt_r + 6'd1);
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the Monte Carlo option pricer: directed rows, then random phases
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 3_000_000;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic [15:0] blk;
    logic [31:0] mean;
    logic [31:0] err;
  } block_res_t;

  typedef struct {
    bit         is_cfg;
    logic [3:0] idx;
    logic [31:0] data;
    bit         typed;
    block_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = mcop_pkg::CFG_START;
  logic [31:0] cfg_data = '0;

  mcop_in_if  in_ch ();
  mcop_out_if out_ch ();

  monte_carlo_option_pricer u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [31:0] m_start, m_strike, m_drift, m_vol, m_disc;
  logic [10:0] m_steps;
  logic [15:0] m_paths;
  logic        m_put;
  logic [31:0] path_price;
  logic [9:0]  step_idx;
  logic [15:0] path_idx;
  logic [63:0] payoff_sum, avg_sum, sq_sum;
  logic [15:0] blocks_done;

  block_res_t expected_blocks[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  logic typed_on = 1'b0;
  block_res_t typed_res = '0;

  function automatic logic [31:0] gbm_step(input logic [31:0] price, input longint x);
    longint k, sh;
    logic [63:0] r, term, e, prod;
    k = x / longint'(mcop_pkg::LN2_Q30);
    if ((x % longint'(mcop_pkg::LN2_Q30)) != 0 && x < 0) k = k - 1;
    r = 64'(x - k * longint'(mcop_pkg::LN2_Q30));
    term = 64'(mcop_pkg::ONE_Q30);
    e = 64'(mcop_pkg::ONE_Q30);
    for (int i = 1; i <= 12; i++) begin
      term = ((term * r) >> 30) / i;
      e = e + term;
    end
    prod = {32'd0, price} * e;
    sh = k - 30;
    if (sh >= 0) begin
      if (prod == 0) return 32'd0;
      if (sh >= 32 || (prod >> (63 - sh)) != 0) return 32'hFFFF_FFFF;
      prod = prod << sh;
    end else begin
      prod = (-sh >= 64) ? 64'd0 : prod >> (-sh);
    end
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic void pricer_reset();
    m_start = 32'd6553600; m_strike = 32'd6553600; m_drift = 32'd738198;
    m_vol = 32'd26843546; m_disc = 32'd3886247062;
    m_steps = 11'd100; m_paths = 16'd1000; m_put = 1'b0;
    path_price = m_start; step_idx = 0; path_idx = 0;
    payoff_sum = 0; blocks_done = 0; avg_sum = 0; sq_sum = 0;
  endfunction

  function automatic void pricer_config(input logic [3:0] idx, input logic [31:0] d);
    case (idx)
      mcop_pkg::CFG_START:  m_start = d;
      mcop_pkg::CFG_STRIKE: m_strike = d;
      mcop_pkg::CFG_DRIFT:  m_drift = d;
      mcop_pkg::CFG_VOL:    m_vol = d;
      mcop_pkg::CFG_DISC:   m_disc = d;
      mcop_pkg::CFG_STEPS:  m_steps = d[10:0];
      mcop_pkg::CFG_PATHS:  m_paths = d[15:0];
      mcop_pkg::CFG_PUT:    m_put = d[0];
      default: ;
    endcase
  endfunction

  // returns 1 when the sample closes a block
  function automatic bit pricer_sample(input logic signed [15:0] z, output block_res_t res);
    longint x, vz;
    int unsigned steps, paths, counted;
    logic [31:0] payoff;
    logic [63:0] avg, sq, n, mean, msq, m2, var_q, err;
    res = '0;
    vz = longint'($signed(m_vol)) * longint'(z);
    x = longint'($signed(m_drift)) + (vz >>> 12);
    steps = m_steps; paths = m_paths;
    if (steps == 0) steps = 1;
    if (steps > 1024) steps = 1024;
    if (paths == 0) paths = 1;
    path_price = gbm_step(path_price, x);
    if (step_idx + 1 < steps) begin
      step_idx = step_idx + 1;
      return 1'b0;
    end
    if (m_put) payoff = (m_strike > path_price) ? m_strike - path_price : 32'd0;
    else payoff = (path_price > m_strike) ? path_price - m_strike : 32'd0;
    payoff_sum = payoff_sum + (({32'd0, payoff} * {32'd0, m_disc}) >> 32);
    path_price = m_start;
    step_idx = 0;
    if (path_idx + 1 < paths) begin
      path_idx = path_idx + 1;
      return 1'b0;
    end
    counted = path_idx + 1;
    avg = payoff_sum / counted;
    payoff_sum = 0;
    path_idx = 0;
    if (blocks_done == 16'hFFFF) begin
      blocks_done = 0; avg_sum = 0; sq_sum = 0;
    end
    blocks_done = blocks_done + 1;
    avg_sum = avg_sum + avg;
    sq = avg * avg;
    sq_sum = (sq_sum > ~sq) ? '1 : sq_sum + sq;
    n = blocks_done;
    mean = avg_sum / n;
    err = 0;
    if (n > 1) begin
      msq = sq_sum / n;
      m2 = mean * mean;
      var_q = (msq > m2) ? msq - m2 : 64'd0;
      err = isqrt(var_q / (n - 1));
    end
    res.blk = n[15:0];
    res.mean = mean[31:0];
    res.err = err[31:0];
    return 1'b1;
  endfunction

  initial pricer_reset();

  // sample side: config writes, accepted samples, accepted results
  always @(posedge clk) begin
    block_res_t r, e;
    cycles <= cycles + 1;
    if (rst_n && cfg_we) pricer_config(cfg_index, cfg_data);
    if (in_ch.valid && in_ch.ready) begin
      if (pricer_sample(in_ch.z_sample, r)) expected_blocks.push_back(typed_on ? typed_res : r);
    end
    if (out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result beat, block_number %0d", out_ch.block_number);
        errors++;
      end else begin
        e = expected_blocks.pop_front();
        if (out_ch.block_number !== e.blk) begin
          $error("block_number expected %0d got %0d", e.blk, out_ch.block_number);
          errors++;
        end
        if (out_ch.running_mean !== e.mean) begin
          $error("running_mean expected %0h got %0h", e.mean, out_ch.running_mean);
          errors++;
        end
        if (out_ch.running_error !== e.err) begin
          $error("running_error expected %0h got %0h", e.err, out_ch.running_error);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    int hold_left;
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  task automatic send_z(input logic [15:0] z, input bit typed, input block_res_t res);
    if (!quiet && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.z_sample <= z;
    typed_on <= typed;
    typed_res <= res;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t cfg_row(input logic [3:0] idx, input logic [31:0] d);
    row_t r;
    r = '{1'b1, idx, d, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t z_row(input logic [15:0] z, input bit typed, input logic [15:0] blk);
    row_t r;
    r = '{1'b0, mcop_pkg::CFG_START, {16'd0, z}, typed, '{blk, 32'd0, 32'd0}};
    return r;
  endfunction

  function automatic logic [31:0] pick_drift();
    case ($urandom_range(3))
      0: return $urandom();
      default: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
    endcase
  endfunction

  initial begin
    row_t rows[$];
    bit was_z;
    int n_items;
    in_ch.valid = 1'b0;
    in_ch.z_sample = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero step and path counts act as one; payoff forced to zero
    rows.push_back(cfg_row(mcop_pkg::CFG_STEPS, 32'd0));
    rows.push_back(cfg_row(mcop_pkg::CFG_PATHS, 32'd0));
    rows.push_back(cfg_row(mcop_pkg::CFG_PUT, 32'd1));
    rows.push_back(cfg_row(mcop_pkg::CFG_STRIKE, 32'd0));
    rows.push_back(z_row(16'h8000, 1'b1, 16'd1));
    rows.push_back(z_row(16'h7FFF, 1'b1, 16'd2));
    rows.push_back(cfg_row(mcop_pkg::CFG_PUT, 32'd0));
    rows.push_back(cfg_row(mcop_pkg::CFG_STRIKE, 32'hFFFF_FFFF));
    rows.push_back(z_row(16'h7FFF, 1'b1, 16'd3));
    rows.push_back(cfg_row(mcop_pkg::CFG_STRIKE, 32'd0));
    rows.push_back(cfg_row(mcop_pkg::CFG_DISC, 32'd0));
    rows.push_back(z_row(16'h0000, 1'b1, 16'd4));
    // saturating price, extreme exponents
    rows.push_back(cfg_row(mcop_pkg::CFG_DISC, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(mcop_pkg::CFG_VOL, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(mcop_pkg::CFG_DRIFT, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(mcop_pkg::CFG_START, 32'hFFFF_FFFF));
    rows.push_back(z_row(16'h7FFF, 1'b0, 0));
    rows.push_back(z_row(16'h0001, 1'b0, 0));
    rows.push_back(cfg_row(mcop_pkg::CFG_VOL, 32'h8000_0000));
    rows.push_back(cfg_row(mcop_pkg::CFG_DRIFT, 32'h8000_0000));
    rows.push_back(z_row(16'h7FFF, 1'b0, 0));
    rows.push_back(z_row(16'h8000, 1'b0, 0));
    rows.push_back(z_row(16'hFFFF, 1'b0, 0));
    // multi-step paths, multi-path blocks
    rows.push_back(cfg_row(mcop_pkg::CFG_START, 32'd6553600));
    rows.push_back(cfg_row(mcop_pkg::CFG_DRIFT, 32'd738198));
    rows.push_back(cfg_row(mcop_pkg::CFG_VOL, 32'd26843546));
    rows.push_back(cfg_row(mcop_pkg::CFG_STEPS, 32'd3));
    rows.push_back(cfg_row(mcop_pkg::CFG_PATHS, 32'd2));
    for (int i = 0; i < 6; i++) rows.push_back(z_row(16'(i * 3001 - 9000), 1'b0, 0));
    // path bound lowered mid run
    rows.push_back(cfg_row(mcop_pkg::CFG_STEPS, 32'd1));
    rows.push_back(cfg_row(mcop_pkg::CFG_PATHS, 32'hFFFF));
    for (int i = 0; i < 3; i++) rows.push_back(z_row(16'(i * 1000), 1'b0, 0));
    rows.push_back(cfg_row(mcop_pkg::CFG_PATHS, 32'd2));
    rows.push_back(z_row(16'h0400, 1'b0, 0));
    // step bound lowered mid run
    rows.push_back(cfg_row(mcop_pkg::CFG_PATHS, 32'd1));
    rows.push_back(cfg_row(mcop_pkg::CFG_STEPS, 32'd1000));
    rows.push_back(z_row(16'h0100, 1'b0, 0));
    rows.push_back(z_row(16'hF000, 1'b0, 0));
    rows.push_back(cfg_row(mcop_pkg::CFG_STEPS, 32'd1));
    rows.push_back(z_row(16'h0200, 1'b0, 0));

    was_z = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (was_z) drain();
        was_z = 1'b0;
        cfg_write(rows[i].idx, rows[i].data);
      end else begin
        was_z = 1'b1;
        send_z(rows[i].data[15:0], rows[i].typed, rows[i].res);
      end
    end
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(mcop_pkg::CFG_START, ($urandom_range(3) == 0) ? $urandom() :
                32'($urandom_range(1 << 20, 200 << 16)));
      cfg_write(mcop_pkg::CFG_STRIKE, ($urandom_range(3) == 0) ? $urandom() :
                32'($urandom_range(1 << 20, 200 << 16)));
      cfg_write(mcop_pkg::CFG_DRIFT, pick_drift());
      cfg_write(mcop_pkg::CFG_VOL, ($urandom_range(3) == 0) ? $urandom() :
                32'($urandom_range(0, 80000000)));
      cfg_write(mcop_pkg::CFG_DISC, ($urandom_range(4) == 0) ?
                $urandom_range(1) * 32'hFFFF_FFFF : $urandom());
      cfg_write(mcop_pkg::CFG_PUT, $urandom_range(1));
      if (ph == 11) begin
        cfg_write(mcop_pkg::CFG_STEPS, 32'd2047);
        cfg_write(mcop_pkg::CFG_PATHS, 32'd1);
        n_items = 1024;
      end else begin
        cfg_write(mcop_pkg::CFG_STEPS, 32'($urandom_range(0, 4)));
        cfg_write(mcop_pkg::CFG_PATHS, 32'($urandom_range(0, 5)));
        n_items = 90;
      end
      quiet = (ph == 3);
      for (int i = 0; i < n_items; i++) begin
        if (ph == 2 && i == 20) hold_go = 1'b1;
        if (ph == 5 && i == 50) drain();
        send_z(16'($urandom()), 1'b0, '0);
      end
      drain();
      quiet = 1'b0;
    end

    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
